/* src/assert_macros.svh */
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* src/knn_pkg.sv */
// Shared types and constants for the k-nearest-neighbor insertion unit.
`timescale 1ns / 1ps
package knn_pkg;
    localparam int MaxNeighbors = 16;
    localparam int SlotBits = $clog2(MaxNeighbors);
    localparam int KBits = 5;
    localparam int IndexBits = 16;
    localparam int DistBits = 34;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_REF = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'd0;
    localparam logic [0:0] REG_EXCLUDE_SELF = 1'd1;

    typedef struct packed {
        logic load_query;
        logic load_ref;
        logic insert;
        logic flush_step;
        logic [SlotBits-1:0] flush_slot;
    } ctrl_t;

    typedef struct packed {
        logic skip;
    } status_t;
endpackage

/* src/knn_datapath.sv */
// Datapath: query store, distance pipeline and sorted insertion row.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module knn_datapath
(
    input  logic clk,
    input  logic rst_n,
    input  knn_pkg::ctrl_t ctrl,
    output knn_pkg::status_t status,
    input  logic [knn_pkg::SlotBits-1:0] k_last,
    input  logic exclude_self,
    input  logic signed [15:0] coord_0,
    input  logic signed [15:0] coord_1,
    input  logic signed [15:0] coord_2,
    input  logic signed [15:0] coord_3,
    input  logic [15:0] point_index,
    output logic [knn_pkg::IndexBits-1:0] out_index,
    output logic [knn_pkg::DistBits-1:0] out_dist,
    output logic out_valid
);
    localparam int N = knn_pkg::MaxNeighbors;
    logic signed [15:0] q_reg [4];
    logic [15:0] qid_reg;
    logic [33:0] sq_reg [4];
    logic [15:0] ridx_reg;
    logic [knn_pkg::DistBits-1:0] dist_reg [N];
    logic [knn_pkg::IndexBits-1:0] idx_reg [N];
    logic [N-1:0] fill_reg;
    logic [N-1:0] fill_next;
    logic [33:0] ref_dist;
    logic [N-1:0] le;
    logic accept;
    logic signed [16:0] diff [4];
    logic [16:0] mag [4];

    assign status.skip = exclude_self && (point_index == qid_reg);

    always_comb
    begin
        diff[0] = 17'(coord_0) - 17'(q_reg[0]);
        diff[1] = 17'(coord_1) - 17'(q_reg[1]);
        diff[2] = 17'(coord_2) - 17'(q_reg[2]);
        diff[3] = 17'(coord_3) - 17'(q_reg[3]);
        for (int d = 0; d < 4; d++)
        begin
            mag[d] = diff[d][16] ? 17'(-diff[d]) : 17'(diff[d]);
        end
    end

    // query point starts at zero so references before any start use the origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < 4; d++)
            begin
                q_reg[d] <= '0;
            end
            qid_reg <= '0;
        end
        else if (ctrl.load_query)
        begin
            q_reg[0] <= coord_0;
            q_reg[1] <= coord_1;
            q_reg[2] <= coord_2;
            q_reg[3] <= coord_3;
            qid_reg <= point_index;
        end
    end

    // stage 1: squares; stage 2: sum and insert
    always_ff @(posedge clk)
    begin
        if (ctrl.load_ref)
        begin
            for (int d = 0; d < 4; d++)
            begin
                sq_reg[d] <= 34'(mag[d]) * 34'(mag[d]);
            end
            ridx_reg <= point_index;
        end
    end

    assign ref_dist = sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            le[i] = (!fill_reg[i] || ref_dist <= dist_reg[i]) && (i <= int'(k_last));
        end
        accept = !fill_reg[k_last] || (ref_dist < dist_reg[k_last]);
        fill_next = fill_reg;
        if (ctrl.insert && accept)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i <= int'(k_last))
                begin
                    if (le[i] && (i == 0 || !le[i-1]))
                    begin
                        fill_next[i] = 1'b1;
                    end
                    else if (i > 0 && le[i-1])
                    begin
                        fill_next[i] = fill_reg[i-1];
                    end
                end
            end
        end
        if (ctrl.load_query)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && accept)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i <= int'(k_last))
                begin
                    if (le[i] && (i == 0 || !le[i-1]))
                    begin
                        dist_reg[i] <= ref_dist;
                        idx_reg[i] <= ridx_reg;
                    end
                    else if (i > 0 && le[i-1])
                    begin
                        dist_reg[i] <= dist_reg[i-1];
                        idx_reg[i] <= idx_reg[i-1];
                    end
                end
            end
        end
    end

    assign out_valid = fill_reg[ctrl.flush_slot];
    assign out_index = out_valid ? idx_reg[ctrl.flush_slot] : '0;
    assign out_dist = out_valid ? dist_reg[ctrl.flush_slot] : '0;

    `ASSERT_NEXT(a_clear, clk, rst_n, ctrl.load_query, fill_reg == '0)
    `ASSERT_IMPLIES(a_excl, clk, rst_n, ctrl.load_query && ctrl.load_ref, 1'b0)
    `ASSERT_NEXT(a_fill, clk, rst_n, ctrl.insert && accept && !ctrl.load_query, fill_reg[0])
endmodule

/* src/knn_ctrl.sv */
// Controller: command decode, insert pipeline timing and flush sequencing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module knn_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [1:0] cmd,
    input  logic [knn_pkg::SlotBits-1:0] k_last,
    input  knn_pkg::status_t status,
    output knn_pkg::ctrl_t ctrl,
    output logic busy,
    output logic strobe,
    output logic last
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_INS = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;
    state_t state_reg, state_next;
    logic [knn_pkg::SlotBits-1:0] slot_reg, slot_next;
    logic req;

    assign req = start && !busy;
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        ctrl = '0;
        ctrl.flush_slot = slot_reg;
        strobe = 1'b0;
        last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req)
                begin
                    case (cmd)
                        knn_pkg::CMD_START: ctrl.load_query = 1'b1;
                        knn_pkg::CMD_REF:
                        begin
                            if (!status.skip)
                            begin
                                ctrl.load_ref = 1'b1;
                                state_next = ST_INS;
                            end
                        end
                        knn_pkg::CMD_FLUSH:
                        begin
                            slot_next = '0;
                            state_next = ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS:
            begin
                ctrl.insert = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                ctrl.flush_step = 1'b1;
                strobe = 1'b1;
                last = (slot_reg == k_last);
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
        end
    end

    `ASSERT_IMPLIES(a_strobe, clk, rst_n, strobe, state_reg == ST_FLUSH)
    `ASSERT_NEXT(a_ins, clk, rst_n, ctrl.load_ref, ctrl.insert)
    `ASSERT_IMPLIES(a_slot, clk, rst_n, strobe, slot_reg <= k_last)
endmodule

/* src/knn_sorted_insertion_unit.sv */
// Top level of the k-nearest-neighbor sorted insertion unit.
// A reference request registers the distance squares, then sums them and inserts;
// a start request loads the query point; a flush gives one result a cycle.
// The single insertion row holds busy high while it inserts, so no new request is taken then.
// Reset clears the slot flags, K to 5 and exclude_self to 0; results cannot stall.
`timescale 1ns / 1ps
module knn_sorted_insertion_unit
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] cmd,
    input  logic signed [15:0] coord_0,
    input  logic signed [15:0] coord_1,
    input  logic signed [15:0] coord_2,
    input  logic signed [15:0] coord_3,
    input  logic [15:0] point_index,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_data,
    output logic strobe,
    output logic [3:0] rank,
    output logic [15:0] neighbor_index,
    output logic [33:0] distance_sq,
    output logic slot_valid,
    output logic last
);
    logic [4:0] k_reg;
    logic excl_reg;
    logic [knn_pkg::SlotBits-1:0] k_last;
    knn_pkg::ctrl_t ctrl;
    knn_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 5'd5;
            excl_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                knn_pkg::REG_NEIGHBOR_COUNT: k_reg <= cfg_data;
                knn_pkg::REG_EXCLUDE_SELF: excl_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (k_reg == '0)
        begin
            k_last = '0;
        end
        else if (k_reg >= 5'(knn_pkg::MaxNeighbors))
        begin
            k_last = knn_pkg::SlotBits'(knn_pkg::MaxNeighbors - 1);
        end
        else
        begin
            k_last = knn_pkg::SlotBits'(k_reg - 5'd1);
        end
    end

    knn_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .k_last(k_last),
        .status(status), .ctrl(ctrl), .busy(busy), .strobe(strobe), .last(last)
    );

    knn_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .status(status), .k_last(k_last),
        .exclude_self(excl_reg), .coord_0(coord_0), .coord_1(coord_1),
        .coord_2(coord_2), .coord_3(coord_3), .point_index(point_index),
        .out_index(neighbor_index), .out_dist(distance_sq), .out_valid(slot_valid)
    );

    assign rank = ctrl.flush_slot;
endmodule
